// ----- hdl/assert_macros.svh -----
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define MBR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form: antecedent holds, consequent must hold in the same cycle.
`define MBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `MBR_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Implication form: antecedent holds, consequent must hold in the next cycle.
`define MBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  `MBR_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ----- hdl/mbr_pkg.sv -----
// Package: constants, codes and types of the partition selector.
package mbr_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int OFF_W        = $clog2(SECTOR_BYTES);
  localparam int ENTRY_SIZE   = 16;
  localparam int ENTRY_COUNT  = 4;
  localparam int WORD_COUNT   = 2 * ENTRY_COUNT;
  localparam int WORD_W       = 32;
  localparam int REL_W        = $clog2(ENTRY_SIZE * ENTRY_COUNT);

  localparam logic [OFF_W-1:0] TABLE_BASE = OFF_W'(446);
  localparam logic [OFF_W-1:0] TABLE_END  = OFF_W'(446 + ENTRY_SIZE * ENTRY_COUNT);
  localparam logic [OFF_W-1:0] SIG_BASE   = OFF_W'(510);
  localparam logic [OFF_W-1:0] SIG_HIGH   = OFF_W'(511);
  localparam logic [OFF_W-1:0] LAST_OFF   = OFF_W'(SECTOR_BYTES - 1);

  localparam logic [15:0] SIG_MAGIC = 16'hAA55;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_FAIL = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ENTRY_0 = 2'd0,
    ENTRY_1 = 2'd1,
    ENTRY_2 = 2'd2,
    ENTRY_3 = 2'd3
  } entry_t;

  localparam entry_t PREFERRED_ENTRY = ENTRY_1;

  typedef enum logic [1:0] {
    STAT_WHOLE    = 2'd0,
    STAT_ENTRY1   = 2'd1,
    STAT_FALLBACK = 2'd2,
    STAT_NO_DISK  = 2'd3
  } status_t;

  typedef logic [WORD_COUNT-1:0][WORD_W-1:0] entry_words_t;

  // Sector end or read failure waiting for the decision stage.
  typedef struct packed {
    logic pending;
    logic fail;
  } mbr_event_t;

  // Decision stage status seen by the capture stage.
  typedef struct packed {
    logic full;   // result register holds an undelivered item
    logic take;   // decision stage consumes the pending event this cycle
  } mbr_sel_stat_t;

endpackage

// ----- hdl/mbr_ifs.sv -----
// Channel interfaces: sector byte input, result output, configuration write.
interface mbr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface mbr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] part_start;
  logic [31:0] part_len;
  logic [1:0]  entry_index;
  logic [1:0]  status;
  modport source (output valid, output part_start, output part_len,
                  output entry_index, output status, input ready);
  modport sink   (input valid, input part_start, input part_len,
                  input entry_index, input status, output ready);
endinterface

interface mbr_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] disk_sectors;
  modport source (output valid, output disk_sectors, input ready);
  modport sink   (input valid, input disk_sectors, output ready);
endinterface

// ----- hdl/mbr_capture.sv -----
// Byte capture: offset counter, partition entry words, signature, event flag.
module mbr_capture import mbr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  mbr_in_if.sink        in_if,
  input  mbr_sel_stat_t sel_st,
  output mbr_event_t    ev,
  output entry_words_t  words,
  output logic [15:0]   sig
);

  logic [OFF_W-1:0] off_r;
  entry_words_t     words_r;
  logic [15:0]      sig_r;
  mbr_event_t       ev_r;

  logic             acc;
  logic             in_table;
  logic [OFF_W-1:0] rel_full;
  logic [REL_W-1:0] rel;
  logic [2:0]       widx;
  logic [1:0]       lane;

  // Stall only while an event waits behind a result that is not leaving.
  assign in_if.ready = !ev_r.pending || sel_st.take;
  assign acc         = in_if.valid && in_if.ready;

  assign in_table = (off_r >= TABLE_BASE) && (off_r < TABLE_END);
  assign rel_full = off_r - TABLE_BASE;
  assign rel      = rel_full[REL_W-1:0];
  // rel[5:4] slot, rel[3] selects the start/length half, rel[2] the word
  assign widx     = {rel[5:4], rel[2]};
  assign lane     = rel[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      words_r <= '0;
      sig_r   <= '0;
      ev_r    <= '0;
    end else begin
      // a new event only arrives once the previous one is taken
      if (acc && (op_t'(in_if.op) == OP_FAIL || off_r == LAST_OFF)) begin
        ev_r <= '{pending: 1'b1, fail: (op_t'(in_if.op) == OP_FAIL)};
      end else if (sel_st.take) begin
        ev_r.pending <= 1'b0;
      end
      if (acc) begin
        if (op_t'(in_if.op) == OP_FAIL) begin
          off_r <= '0;
        end else begin
          if (in_table && rel[3]) begin
            words_r[widx][lane*8 +: 8] <= in_if.data_byte;
          end else if (off_r == SIG_BASE) begin
            sig_r[7:0] <= in_if.data_byte;
          end else if (off_r == SIG_HIGH) begin
            sig_r[15:8] <= in_if.data_byte;
          end
          if (off_r == LAST_OFF) begin
            off_r <= '0;
          end else begin
            off_r <= off_r + 1'b1;
          end
        end
      end
    end
  end

  assign ev    = ev_r;
  assign words = words_r;
  assign sig   = sig_r;

endmodule

// ----- hdl/mbr_select.sv -----
// Decision stage: disk size register, slot checks, result register.
module mbr_select import mbr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  mbr_cfg_if.sink       cfg_if,
  input  mbr_event_t    ev,
  input  entry_words_t  words,
  input  logic [15:0]   sig,
  output mbr_sel_stat_t sel_st,
  mbr_out_if.source     out_if
);

  logic [31:0] disk_r;

  logic        out_valid_r;
  logic [31:0] start_r;
  logic [31:0] count_r;
  entry_t      index_r;
  status_t     status_r;

  logic [31:0] start_nxt;
  logic [31:0] count_nxt;
  entry_t      index_nxt;
  status_t     status_nxt;

  logic [ENTRY_COUNT-1:0]             ok;
  logic [ENTRY_COUNT-1:0][WORD_W-1:0] clamp;
  logic [ENTRY_COUNT-1:0][WORD_W-1:0] left;
  logic                               take;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_r <= '0;
    end else if (cfg_if.valid) begin
      disk_r <= cfg_if.disk_sectors;
    end
  end

  // Per-slot usability and clamp to the sectors left after the start.
  always_comb begin
    for (int k = 0; k < ENTRY_COUNT; k++) begin
      left[k]  = disk_r - words[2*k];
      ok[k]    = (words[2*k] != '0) && (words[2*k+1] != '0) && (words[2*k] < disk_r);
      clamp[k] = (words[2*k+1] > left[k]) ? left[k] : words[2*k+1];
    end
  end

  always_comb begin
    start_nxt  = '0;
    count_nxt  = disk_r;
    index_nxt  = ENTRY_0;
    status_nxt = STAT_WHOLE;
    priority if (disk_r == '0) begin
      count_nxt  = '0;
      status_nxt = STAT_NO_DISK;
    end else if (ev.fail || sig != SIG_MAGIC) begin
      count_nxt = disk_r;
    end else if (ok[PREFERRED_ENTRY]) begin
      start_nxt  = words[2*PREFERRED_ENTRY];
      count_nxt  = clamp[PREFERRED_ENTRY];
      index_nxt  = PREFERRED_ENTRY;
      status_nxt = STAT_ENTRY1;
    end else if (ok[ENTRY_0]) begin
      start_nxt  = words[0];
      count_nxt  = clamp[ENTRY_0];
      index_nxt  = ENTRY_0;
      status_nxt = STAT_FALLBACK;
    end else if (ok[ENTRY_2]) begin
      start_nxt  = words[4];
      count_nxt  = clamp[ENTRY_2];
      index_nxt  = ENTRY_2;
      status_nxt = STAT_FALLBACK;
    end else if (ok[ENTRY_3]) begin
      start_nxt  = words[6];
      count_nxt  = clamp[ENTRY_3];
      index_nxt  = ENTRY_3;
      status_nxt = STAT_FALLBACK;
    end else begin
      // no usable slot: whole disk
      count_nxt = disk_r;
    end
  end

  assign take = ev.pending && (!out_valid_r || out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      start_r  <= start_nxt;
      count_r  <= count_nxt;
      index_r  <= index_nxt;
      status_r <= status_nxt;
    end
  end

  assign sel_st.full = out_valid_r;
  assign sel_st.take = take;

  assign out_if.valid       = out_valid_r;
  assign out_if.part_start  = start_r;
  assign out_if.part_len    = count_r;
  assign out_if.entry_index = index_r;
  assign out_if.status      = status_r;

endmodule

// ----- hdl/mbr_partition_select.sv -----
// Top level: partition table capture and selection from the first disk sector.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------------
//  in_if   | in  | valid/ready   | op, data_byte (one sector byte or a read failure)
//  out_if  | out | valid/ready   | part_start, part_len, entry_index, status
//  cfg_if  | in  | valid/ready   | disk_sectors (ready is always high)
//
// Flow: one input item per clock while input ready is high. The result for
// a sector end or a read failure is held in the capture event flag, then set
// by the decision stage into the output register when that stage takes it.
// Reset: rst_n synchronous, active low; clears offset, entry words, signature,
// disk size and all valid flags.
// Stalls: input ready drops only while a decided event waits behind a result
// that the sink does not take in that cycle; plain bytes flow while a result
// sits unread.
module mbr_partition_select import mbr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mbr_in_if.sink    in_if,
  mbr_out_if.source out_if,
  mbr_cfg_if.sink   cfg_if
);

  mbr_event_t    ev;
  mbr_sel_stat_t sel_st;
  entry_words_t  words;
  logic [15:0]   sig;

  // Capture: walks the sector offset and latches the start/length words of
  // the four entries plus the two signature bytes. A sector end or a read
  // failure raises an event for the decision stage.
  mbr_capture u_capture (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .sel_st (sel_st),
    .ev     (ev),
    .words  (words),
    .sig    (sig)
  );

  // Decision: checks all four slots in parallel against the disk size,
  // picks entry one first and then the first usable slot, and registers the
  // result. The next sector's first bytes never touch the table, so the
  // capture registers stay valid while the decision reads them.
  mbr_select u_select (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .ev     (ev),
    .words  (words),
    .sig    (sig),
    .sel_st (sel_st),
    .out_if (out_if)
  );

endmodule

// ----- hdl/mbr_checker.sv -----
// Port-level checker for the partition selector, with its bind.
`include "assert_macros.svh"

module mbr_checker import mbr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_part_start,
  input logic [31:0] out_part_len,
  input logic [1:0]  out_entry_index,
  input logic [1:0]  out_status
);

  `MBR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_part_start) && $stable(out_part_len) && $stable(out_status),
    "result dropped or changed while stalled")
  `MBR_ASSERT_IMP(a_no_disk_zero, clk, rst_n, out_valid && out_status == STAT_NO_DISK,
    out_part_start == '0 && out_part_len == '0 && out_entry_index == ENTRY_0,
    "no-disk result not all zero")
  `MBR_ASSERT_IMP(a_whole_disk, clk, rst_n, out_valid && out_status == STAT_WHOLE,
    out_part_start == '0 && out_entry_index == ENTRY_0,
    "whole-disk result has a slot or start")
  `MBR_ASSERT_IMP(a_entry_one, clk, rst_n, out_valid && out_status == STAT_ENTRY1,
    out_entry_index == ENTRY_1 && out_part_start != '0 && out_part_len != '0,
    "entry one result inconsistent")

endmodule

bind mbr_partition_select mbr_checker u_mbr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_part_start  (out_if.part_start),
  .out_part_len    (out_if.part_len),
  .out_entry_index (out_if.entry_index),
  .out_status      (out_if.status)
);

// ----- dv/tb.sv -----
// Testbench for mbr_partition_select: directed partition tables, read failures, random noise.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbr_pkg::*;

  // Hard stop, well above the slowest legal run with the heaviest idle mix.
  localparam int RUN_LIMIT_CYCLES = 60_000;
  localparam int DRAIN_LIMIT      = 20_000;

  // One decision as it leaves the block.
  typedef struct packed {
    logic [31:0] lba;
    logic [31:0] len;
    entry_t      slot;
    status_t     stat;
  } part_result_t;

  logic clk;
  logic rst_n;

  mbr_in_if  in_ch ();
  mbr_out_if out_ch ();
  mbr_cfg_if cfg_ch ();

  mbr_partition_select dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the selector: byte offset, captured entry words and signature,
  // updated on every accepted item, and disk size, updated on each write.
  // ---------------------------------------------------------------------------
  logic [OFF_W-1:0]  next_off;
  logic [WORD_W-1:0] entry_word [WORD_COUNT];
  logic [15:0]       sig_word;
  logic [31:0]       disk_size;

  part_result_t part_q[$];   // decisions still owed by the block, oldest first

  // Sector image being streamed in.
  logic [7:0] sector_buf [SECTOR_BYTES];

  int in_gap_pct    = 13;
  int out_stall_pct = 45;

  int mismatches;
  int bytes_sent;
  int fails_sent;
  int results_due;
  int results_seen;
  int config_writes;
  int stat_seen [4];

  function automatic void note_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] ERROR %s", $time, msg);
  endfunction

  // Entry usable: nonzero start and length, start inside the disk. Length is
  // cut to the sectors left after the start.
  function automatic bit slot_fits(int slot, output logic [31:0] st, output logic [31:0] cnt);
    st  = entry_word[2 * slot];
    cnt = entry_word[2 * slot + 1];
    if (st == 32'd0 || cnt == 32'd0 || st >= disk_size) return 1'b0;
    if (cnt > disk_size - st) cnt = disk_size - st;
    return 1'b1;
  endfunction

  // Answer for a read failure, bad signature or empty table.
  function automatic part_result_t whole_disk();
    if (disk_size == 32'd0) return '{32'd0, 32'd0, ENTRY_0, STAT_NO_DISK};
    return '{32'd0, disk_size, ENTRY_0, STAT_WHOLE};
  endfunction

  function automatic part_result_t choose_partition();
    part_result_t r;
    logic [31:0]  st;
    logic [31:0]  cnt;
    r = whole_disk();
    if (disk_size != 32'd0 && sig_word == SIG_MAGIC) begin
      if (slot_fits(PREFERRED_ENTRY, st, cnt)) begin
        r = '{st, cnt, PREFERRED_ENTRY, STAT_ENTRY1};
      end else begin
        // walk down so the lowest usable slot is the one that sticks
        for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
          if (slot_fits(i, st, cnt)) r = '{st, cnt, entry_t'(i[1:0]), STAT_FALLBACK};
        end
      end
    end
    return r;
  endfunction

  function automatic void owe_result(part_result_t r);
    part_q.push_back(r);
    results_due++;
  endfunction

  function automatic void predict_item(op_t op, logic [7:0] b);
    int rel;
    int w;
    if (op == OP_FAIL) begin
      fails_sent++;
      next_off = '0;
      owe_result(whole_disk());
    end else begin
      bytes_sent++;
      if (next_off >= TABLE_BASE && next_off < TABLE_END) begin
        rel = int'(next_off - TABLE_BASE);
        // only the start and length words (entry bytes 8..15) are kept
        if (rel % ENTRY_SIZE >= 8) begin
          w = 2 * (rel / ENTRY_SIZE) + (rel % ENTRY_SIZE - 8) / 4;
          entry_word[w][8 * (rel % 4) +: 8] = b;
        end
      end else if (next_off == SIG_BASE) begin
        sig_word[7:0] = b;
      end else if (next_off == SIG_HIGH) begin
        sig_word[15:8] = b;
      end
      if (next_off == LAST_OFF) begin
        next_off = '0;
        owe_result(choose_partition());
      end else begin
        next_off = next_off + 1'b1;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, result sink and result checker
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver stalls are redrawn every cycle.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    part_result_t got;
    part_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.part_start, out_ch.part_len,
              entry_t'(out_ch.entry_index), status_t'(out_ch.status)};
      results_seen++;
      stat_seen[got.stat]++;
      if (part_q.size() == 0) begin
        note_error($sformatf("unexpected result lba=%h len=%h slot=%0d stat=%0d",
                             got.lba, got.len, got.slot, got.stat));
      end else begin
        want = part_q.pop_front();
        if (got.lba !== want.lba || got.len !== want.len ||
            got.slot !== want.slot || got.stat !== want.stat) begin
          note_error($sformatf({"result %0d: expected lba=%h len=%h slot=%0d stat=%0d,",
                                " got lba=%h len=%h slot=%0d stat=%0d"},
                               results_seen, want.lba, want.len, want.slot, want.stat,
                               got.lba, got.len, got.slot, got.stat));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task starts and ends on a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(op_t op, logic [7:0] b);
    while ($urandom_range(99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(op, b);
    @(negedge clk);
  endtask

  // Disk size is only changed with the block idle and every result delivered.
  task automatic set_disk(logic [31:0] v);
    in_ch.valid <= 1'b0;
    while (part_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.disk_sectors <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    disk_size = v;
    config_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // fill: 0 random bytes, 1 all zeros, 2 all ones
  task automatic fill_sector(int fill);
    for (int i = 0; i < SECTOR_BYTES; i++) begin
      case (fill)
        1:       sector_buf[i] = 8'h00;
        2:       sector_buf[i] = 8'hFF;
        default: sector_buf[i] = 8'($urandom);
      endcase
    end
  endtask

  // Little-endian start at entry +8, length at entry +12.
  task automatic put_entry(int slot, logic [31:0] st, logic [31:0] cnt);
    int base;
    base = int'(TABLE_BASE) + slot * ENTRY_SIZE + 8;
    for (int k = 0; k < 4; k++) begin
      sector_buf[base + k]     = st[8 * k +: 8];
      sector_buf[base + 4 + k] = cnt[8 * k +: 8];
    end
  endtask

  task automatic put_sig(logic [15:0] s);
    sector_buf[SIG_BASE] = s[7:0];
    sector_buf[SIG_HIGH] = s[15:8];
  endtask

  task automatic send_bytes(int n);
    for (int i = 0; i < n; i++) send_item(OP_BYTE, sector_buf[i]);
  endtask

  task automatic table_sector(int fill, logic [15:0] s,
                              logic [31:0] s0, logic [31:0] l0, logic [31:0] s1, logic [31:0] l1,
                              logic [31:0] s2, logic [31:0] l2, logic [31:0] s3, logic [31:0] l3);
    fill_sector(fill);
    put_entry(0, s0, l0);
    put_entry(1, s1, l1);
    put_entry(2, s2, l2);
    put_entry(3, s3, l3);
    put_sig(s);
    send_bytes(SECTOR_BYTES);
  endtask

  // ---------------------------------------------------------------------------
  // Random noise: short byte runs mixed with read failures
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_disk();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3, 4:    return $urandom_range(5000, 2);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_noise();
    int n;
    n = $urandom_range(24, 1);
    repeat (n) send_item(($urandom_range(3) == 0) ? OP_FAIL : OP_BYTE, 8'($urandom));
    // usually realign so the next run starts at offset zero
    if ($urandom_range(3) != 0) send_item(OP_FAIL, 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Disk size still zero from reset: every answer is the size-zero status.
  task automatic test_size_zero();
    send_item(OP_FAIL, 8'hFF);
    fill_sector(0);
    send_bytes(6);
    send_item(OP_FAIL, 8'h00);
    set_disk(32'd0);
    send_item(OP_FAIL, 8'h11);
  endtask

  // Read failures back to back and after a partial sector give the whole disk.
  task automatic test_read_failure();
    set_disk(32'd1000);
    send_item(OP_FAIL, 8'h00);
    send_item(OP_FAIL, 8'h5A);
    send_item(OP_FAIL, 8'hA5);
    fill_sector(0);
    send_bytes(17);
    send_item(OP_FAIL, 8'hFF);
  endtask

  // Entry one preferred; its length is cut to the disk end.
  task automatic test_entry_choice();
    set_disk(32'd1000);
    send_item(OP_FAIL, 8'h00);
    table_sector(0, SIG_MAGIC, 32'd10, 32'd5, 32'd900, 32'hFFFF_FFFF,
                 32'd20, 32'd20, 32'd30, 32'd30);
  endtask

  // Entry one starts at zero and slot zero lies past the disk: slot two, clamped.
  task automatic test_fallback_slot();
    set_disk(32'd1000);
    send_item(OP_FAIL, 8'h00);
    table_sector(1, SIG_MAGIC, 32'd2000, 32'd5, 32'd0, 32'd50, 32'd20, 32'd2000,
                 32'd30, 32'd30);
  endtask

  // Random noise under one idle mix; disk size redrawn every few runs.
  task automatic test_random_noise(int gap_pct, int stall_pct, int n_items);
    int items0;
    int n;
    in_gap_pct    = gap_pct;
    out_stall_pct = stall_pct;
    items0 = bytes_sent + fails_sent;
    n      = 0;
    while (bytes_sent + fails_sent - items0 < n_items) begin
      if (n % 4 == 0) set_disk(pick_disk());
      random_noise();
      n++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    int waited;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.op            = OP_BYTE;
    in_ch.data_byte     = 8'h00;
    cfg_ch.valid        = 1'b0;
    cfg_ch.disk_sectors = 32'd0;
    next_off            = '0;
    sig_word            = 16'h0000;
    disk_size           = 32'd0;
    for (int i = 0; i < WORD_COUNT; i++) entry_word[i] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed part runs under the first idle mix
    test_size_zero();
    test_read_failure();
    test_entry_choice();

    test_random_noise(45, 13, 300);
    test_random_noise(0, 0, 60);
    // full sector with neither side idling
    test_fallback_slot();

    // let every owed result come out, bounded
    in_ch.valid <= 1'b0;
    waited = 0;
    while (part_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
    if (part_q.size() != 0) note_error($sformatf("%0d results never arrived", part_q.size()));

    $display("Streamed %0d sector bytes and %0d read failures over %0d disk size writes.",
             bytes_sent, fails_sent, config_writes);
    $display("Checked %0d results: %0d whole disk, %0d entry one, %0d fallback, %0d size zero.",
             results_seen, stat_seen[STAT_WHOLE], stat_seen[STAT_ENTRY1],
             stat_seen[STAT_FALLBACK], stat_seen[STAT_NO_DISK]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_CYCLES * 12);
    $display("Timeout after %0d cycles with %0d results outstanding.",
             RUN_LIMIT_CYCLES, part_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
